// ===== rtl/core/sctg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctg_pkg
// Shared types, codes and helpers of the serial card with tape gating.
// ----------------------------------------------------------------------------
package sctg_pkg;

    // Command codes.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_KEY   = 2'd2;

    // Port codes.
    localparam logic [1:0] PORT_STATUS_LO = 2'd0;
    localparam logic [1:0] PORT_DATA_LO   = 2'd1;
    localparam logic [1:0] PORT_STATUS_HI = 2'd2;
    localparam logic [1:0] PORT_DATA_HI   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_READER_ATTACHED = 1'b0;
    localparam logic CFG_PUNCH_ATTACHED  = 1'b1;

    // Special byte values.
    localparam logic [7:0] STATUS_RESET_CMD = 8'h03;
    localparam logic [7:0] CHAR_DC1         = 8'h11;
    localparam logic [7:0] CHAR_DC2         = 8'h12;
    localparam logic [7:0] CHAR_DC3         = 8'h13;
    localparam logic [7:0] CHAR_DC4         = 8'h14;

    // Stream widths.
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] port;
        logic [7:0] data;
        logic [7:0] tape_byte;
        logic       tape_empty;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       console_valid;
        logic [7:0] console_char;
        logic       punch_valid;
        logic [7:0] punch_char;
        logic       tape_advance;
    } result_t;

    // Status registers only ever hold 0x02 or 0x03, so only RXF is kept.
    // last_status only ever holds 0x00, 0x02 or 0x03, so two bits suffice.
    typedef struct packed {
        logic       console_rxf;
        logic [7:0] console_buffer;
        logic       reader_rxf;
        logic       reader_enabled;
        logic       punch_enabled;
        logic [7:0] last_data;
        logic [1:0] last_status;
        logic       tape_exhausted;
    } state_t;

    typedef struct packed {
        logic reader_attached;
        logic punch_attached;
    } cfg_t;

    function automatic logic is_printed(input logic [7:0] c);
        return (c inside {[8'h20:8'h7E], 8'h0D, 8'h0A});
    endfunction

    function automatic logic [7:0] status_byte(input logic rxf);
        return {6'b0, 1'b1, rxf};
    endfunction

endpackage

// ===== rtl/core/sctg_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctg_step
// Next-state and result logic for one request against the card state.
// ----------------------------------------------------------------------------
module sctg_step
    import sctg_pkg::*;
(
    input  state_t  cur,
    input  cfg_t    cfg,
    input  item_t   item,
    output state_t  nxt,
    output result_t res
);

    always_comb
    begin
        nxt = cur;
        res = '0;
        case (item.command)
            CMD_READ:
            begin
                case (item.port)
                    PORT_STATUS_LO:
                    begin
                        if (cur.reader_enabled)
                        begin
                            nxt.reader_rxf  = cfg.reader_attached && !cur.tape_exhausted;
                            nxt.last_status = {1'b1, nxt.reader_rxf};
                        end
                        else
                        begin
                            nxt.last_status = {1'b1, cur.console_rxf};
                        end
                        res.read_data = {6'b0, nxt.last_status};
                    end
                    PORT_DATA_LO:
                    begin
                        if (cur.reader_enabled)
                        begin
                            if (!cfg.reader_attached)
                            begin
                                res.read_data = 8'h00;
                            end
                            else if (!cur.reader_rxf)
                            begin
                                res.read_data = cur.last_data;
                            end
                            else if (item.tape_empty || cur.tape_exhausted)
                            begin
                                nxt.reader_rxf     = 1'b0;
                                nxt.tape_exhausted = 1'b1;
                                nxt.last_data      = 8'h00;
                            end
                            else
                            begin
                                nxt.last_data    = item.tape_byte;
                                nxt.reader_rxf   = 1'b0;
                                res.tape_advance = 1'b1;
                                res.read_data    = item.tape_byte;
                            end
                        end
                        else
                        begin
                            nxt.console_rxf = 1'b0;
                            nxt.last_data   = cur.console_buffer;
                            res.read_data   = cur.console_buffer;
                        end
                    end
                    PORT_STATUS_HI:
                    begin
                        res.read_data = {6'b0, cur.last_status};
                    end
                    default:
                    begin
                        res.read_data = cur.last_data;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                case (item.port)
                    PORT_STATUS_LO:
                    begin
                        if (item.data == STATUS_RESET_CMD)
                        begin
                            nxt.console_rxf    = 1'b0;
                            nxt.console_buffer = 8'h00;
                            nxt.reader_rxf     = 1'b0;
                        end
                        nxt.last_status = 2'b00;
                    end
                    PORT_DATA_LO:
                    begin
                        if (is_printed(item.data))
                        begin
                            res.console_valid = 1'b1;
                            res.console_char  = item.data;
                            if (cur.punch_enabled && cfg.punch_attached)
                            begin
                                res.punch_valid = 1'b1;
                                res.punch_char  = item.data;
                            end
                        end
                        else
                        begin
                            case (item.data)
                                CHAR_DC1:
                                begin
                                    nxt.reader_enabled = 1'b1;
                                    nxt.reader_rxf     = 1'b1;
                                end
                                CHAR_DC2: nxt.punch_enabled  = 1'b1;
                                CHAR_DC3: nxt.reader_enabled = 1'b0;
                                CHAR_DC4: nxt.punch_enabled  = 1'b0;
                                default:  ;
                            endcase
                        end
                        nxt.last_data = 8'h00;
                    end
                    default: ;
                endcase
            end
            CMD_KEY:
            begin
                nxt.console_buffer = item.data;
                nxt.console_rxf    = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/serial_card_with_tape_gating.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_card_with_tape_gating
// Serial card with console, tape reader and punch, one request per cycle unless the result stream stalls.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle on its slave stream, unless the
// master side stalls, and returns exactly one result per request on its master
// stream, in order. A request is captured in an input register; as it leaves
// that register the card state is updated and the result is loaded into the
// output register. The sustained rate, one request a cycle while unstalled, is
// set by the single pass of the state update logic. Back-pressure on the master
// side stalls the input register only once the output register is occupied and
// not taken. The user must write the two configuration registers (reader and
// punch media attached) through the plain write port while no request is in
// flight; the block does not enforce it. A reader write also clears end-of-tape.
module serial_card_with_tape_gating
    import sctg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: data[7:0], tape_byte[15:8], tape_empty[16], zeros.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: command[1:0], port[3:2].
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: read_data[7:0], console_valid[8], console_char[16:9],
    // punch_valid[17], punch_char[25:18], tape_advance[26], zeros.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic                   cfg_data
);

    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    logic    out_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    cfg_t    cfg_reg;
    state_t  step_state;
    result_t step_res;
    logic    advance;

    // The input register moves on whenever the output register is free or
    // is being emptied in this same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sctg_step u_step
    (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (in_item_reg),
        .nxt  (step_state),
        .res  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.data       <= s_tdata[7:0];
            in_item_reg.tape_byte  <= s_tdata[15:8];
            in_item_reg.tape_empty <= s_tdata[16];
            in_item_reg.command    <= s_tuser[1:0];
            in_item_reg.port       <= s_tuser[3:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    // The state follows the request leaving the input register. Configuration
    // writes are to arrive only while idle; the block does not enforce this.
    always_comb
    begin
        state_next = advance ? step_state : state_reg;
        if (cfg_we && (cfg_index == CFG_READER_ATTACHED))
        begin
            state_next.tape_exhausted = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_READER_ATTACHED: cfg_reg.reader_attached <= cfg_data;
                CFG_PUNCH_ATTACHED:  cfg_reg.punch_attached  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, res_reg.tape_advance, res_reg.punch_char,
                       res_reg.punch_valid, res_reg.console_char,
                       res_reg.console_valid, res_reg.read_data};

`ifndef SYNTHESIS
    // The input side only stalls when both registers are full and blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked output");

    // A punched character is always echoed on the console.
    a_punch_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.punch_valid) |->
            (res_reg.console_valid && (res_reg.punch_char == res_reg.console_char)))
        else $error("punch character without matching console character");

    // A tape byte handed out is the latched data while the result waits.
    a_tape_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.tape_advance) |->
            (res_reg.read_data == state_reg.last_data))
        else $error("tape byte not latched as last data");

    // A stalled result leaves the card state untouched.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && !cfg_we) |=> $stable(state_reg))
        else $error("state changed while the result was stalled");
`endif

endmodule

// ===== sim/serial_card_with_tape_gating_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_card_with_tape_gating_tb
// Self-checking bench for the serial card with console, tape reader and punch.
// ----------------------------------------------------------------------------
// A queue of requests is filled by the stimulus process. A clocked driver
// offers them on the slave stream, and a clocked monitor predicts each result
// when the request is accepted, then compares every returned result, field by
// field, with the oldest prediction. A short directed sequence is followed by
// twelve random phases. Each phase rewrites the media registers and sets how
// often each side of the streams idles.
// ----------------------------------------------------------------------------
module serial_card_with_tape_gating_tb;
    import sctg_pkg::*;

    // The command field is two bits wide, so one code is left undefined.
    localparam logic [1:0] CMD_UNDEFINED = 2'd3;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] PRINT_FIRST   = 8'h20;
    localparam logic [7:0] PRINT_LAST    = 8'h7E;
    localparam int         PHASES        = 12;
    localparam int         PHASE_REQS    = 160;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic                   cfg_index;
    logic                   cfg_data;

    serial_card_with_tape_gating dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting to be offered, and results predicted but not yet seen.
    item_t   pending_requests[$];
    result_t expected_results[$];

    // Copy of the card state as the bench expects it to be.
    logic [7:0] console_stat;
    logic [7:0] console_buf;
    logic [7:0] reader_stat;
    logic       reader_on;
    logic       punch_on;
    logic [7:0] held_data;
    logic [7:0] held_status;
    logic       tape_out;
    logic       reader_media;
    logic       punch_media;

    // Flow control between the stimulus process, the driver and the monitor.
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_requests;
    logic request_taken;
    int   requests_queued;
    int   requests_accepted;
    int   results_checked;
    int   console_chars;
    int   punch_chars;
    int   tape_advances;
    int   failures;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: applies one request to the expected card state and returns
    // the result that the block should produce for it.
    // ------------------------------------------------------------------------
    function automatic result_t serve_request(input item_t rq);
        result_t r;
        logic    printable;
        r = '0;
        printable = (rq.data >= PRINT_FIRST && rq.data <= PRINT_LAST) ||
                    rq.data == CHAR_CR || rq.data == CHAR_LF;
        case (rq.command)
            CMD_READ:
            begin
                case (rq.port)
                    PORT_STATUS_LO:
                    begin
                        if (reader_on)
                        begin
                            // Polling the reader refreshes its RXF from the media.
                            reader_stat[0] = reader_media && !tape_out;
                            held_status = reader_stat;
                        end
                        else
                        begin
                            held_status = console_stat;
                        end
                        r.read_data = held_status;
                    end
                    PORT_DATA_LO:
                    begin
                        if (!reader_on)
                        begin
                            console_stat[0] = 1'b0;
                            held_data = console_buf;
                            r.read_data = held_data;
                        end
                        else if (!reader_media)
                        begin
                            r.read_data = 8'h00;
                        end
                        else if (!reader_stat[0])
                        begin
                            r.read_data = held_data;
                        end
                        else if (rq.tape_empty || tape_out)
                        begin
                            // End of tape: the reader stays dry until media is refitted.
                            reader_stat[0] = 1'b0;
                            tape_out = 1'b1;
                            held_data = 8'h00;
                        end
                        else
                        begin
                            held_data = rq.tape_byte;
                            reader_stat[0] = 1'b0;
                            r.tape_advance = 1'b1;
                            r.read_data = rq.tape_byte;
                        end
                    end
                    PORT_STATUS_HI: r.read_data = held_status;
                    default:        r.read_data = held_data;
                endcase
            end
            CMD_WRITE:
            begin
                if (rq.port == PORT_STATUS_LO)
                begin
                    if (rq.data == STATUS_RESET_CMD)
                    begin
                        console_stat = 8'h02;
                        console_buf = 8'h00;
                        reader_stat = 8'h02;
                    end
                    held_status = 8'h00;
                end
                else if (rq.port == PORT_DATA_LO)
                begin
                    if (printable)
                    begin
                        r.console_valid = 1'b1;
                        r.console_char = rq.data;
                        if (punch_on && punch_media)
                        begin
                            r.punch_valid = 1'b1;
                            r.punch_char = rq.data;
                        end
                    end
                    else if (rq.data == CHAR_DC1)
                    begin
                        reader_on = 1'b1;
                        reader_stat[0] = 1'b1;
                    end
                    else if (rq.data == CHAR_DC2)
                    begin
                        punch_on = 1'b1;
                    end
                    else if (rq.data == CHAR_DC3)
                    begin
                        reader_on = 1'b0;
                    end
                    else if (rq.data == CHAR_DC4)
                    begin
                        punch_on = 1'b0;
                    end
                    held_data = 8'h00;
                end
            end
            CMD_KEY:
            begin
                console_buf = rq.data;
                console_stat[0] = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic put(input logic [1:0] cmd, input logic [1:0] port, input logic [7:0] data,
                       input logic [7:0] tape_byte, input logic tape_empty);
        item_t rq;
        rq.command = cmd;
        rq.port = port;
        rq.data = data;
        rq.tape_byte = tape_byte;
        rq.tape_empty = tape_empty;
        pending_requests.push_back(rq);
        requests_queued++;
    endtask

    // Random read of a low or high port with random filler in the unused fields.
    task automatic put_read(input logic [1:0] port, input int empty_one_in);
        put(CMD_READ, port, 8'($urandom_range(255)), 8'($urandom_range(255)),
            $urandom_range(empty_one_in - 1) == 0);
    endtask

    task automatic put_write(input logic [1:0] port, input logic [7:0] data);
        put(CMD_WRITE, port, data, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // One well-formed session with random content, or a piece of noise.
    task automatic queue_scenario();
        int pick;
        int n;
        pick = $urandom_range(9);
        if (pick <= 2)
        begin
            // Reader session: switch on, then poll and read the tape.
            put_write(PORT_DATA_LO, CHAR_DC1);
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                put_read(PORT_STATUS_LO, 1000000);
                put_read(PORT_DATA_LO, 20);
                if ($urandom_range(3) == 0)
                    put_read(PORT_DATA_LO, 20);
                if ($urandom_range(3) == 0)
                    put_read(2'($urandom_range(PORT_STATUS_HI, PORT_DATA_HI)), 2);
            end
            if ($urandom_range(1))
                put_write(PORT_DATA_LO, CHAR_DC3);
        end
        else if (pick <= 4)
        begin
            // Punch session: switch on and print a short line.
            put_write(PORT_DATA_LO, CHAR_DC2);
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                if ($urandom_range(9) == 0)
                    put_write(PORT_DATA_LO, $urandom_range(1) ? CHAR_CR : CHAR_LF);
                else
                    put_write(PORT_DATA_LO, 8'($urandom_range(PRINT_FIRST, PRINT_LAST)));
            end
            if ($urandom_range(1))
                put_write(PORT_DATA_LO, CHAR_DC4);
        end
        else if (pick <= 6)
        begin
            // Keystroke followed by the usual poll and fetch.
            put(CMD_KEY, 2'($urandom_range(3)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 1'($urandom_range(1)));
            put_read(PORT_STATUS_LO, 2);
            put_read(PORT_DATA_LO, 2);
            if ($urandom_range(1))
                put_read(2'($urandom_range(PORT_STATUS_HI, PORT_DATA_HI)), 2);
        end
        else if (pick == 7)
        begin
            put_write(PORT_STATUS_LO,
                      $urandom_range(1) ? STATUS_RESET_CMD : 8'($urandom_range(255)));
        end
        else if (pick == 8)
        begin
            put(2'($urandom_range(3)), 2'($urandom_range(3)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        else
        begin
            put_write(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    task automatic write_cfg(input logic idx, input logic value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued request has gone and every result has come,
    // then lets the two pipeline stages settle.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: a new request is presented on the falling edge once the previous
    // one has been taken, or after an idle cycle.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (request_taken || !s_tvalid))
        begin
            request_taken = 1'b0;
            if (pending_requests.size() != 0 && !hold_requests &&
                $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {7'b0, pending_requests[0].tape_empty,
                            pending_requests[0].tape_byte, pending_requests[0].data};
                s_tuser <= {pending_requests[0].port, pending_requests[0].command};
                pending_requests.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random, as often as the current phase asks.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: on each rising edge, returned results are checked first, then
    // a configuration write or an accepted request updates the prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        item_t   rq;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    failures++;
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, m_tdata[7:0]);
                    check_field("console_valid", 8'(want.console_valid), 8'(m_tdata[8]));
                    check_field("console_char", want.console_char, m_tdata[16:9]);
                    check_field("punch_valid", 8'(want.punch_valid), 8'(m_tdata[17]));
                    check_field("punch_char", want.punch_char, m_tdata[25:18]);
                    check_field("tape_advance", 8'(want.tape_advance), 8'(m_tdata[26]));
                    results_checked++;
                    console_chars += want.console_valid;
                    punch_chars += want.punch_valid;
                    tape_advances += want.tape_advance;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_READER_ATTACHED)
                begin
                    reader_media = cfg_data;
                    tape_out = 1'b0;
                end
                else
                begin
                    punch_media = cfg_data;
                end
            end
            if (s_tvalid && s_tready)
            begin
                rq.command = s_tuser[1:0];
                rq.port = s_tuser[3:2];
                rq.data = s_tdata[7:0];
                rq.tape_byte = s_tdata[15:8];
                rq.tape_empty = s_tdata[16];
                expected_results.push_back(serve_request(rq));
                request_taken = 1'b1;
                requests_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, a directed sequence, then the random phases.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 1'b0;
        console_stat = 8'h02;
        console_buf = 8'h00;
        reader_stat = 8'h02;
        reader_on = 1'b0;
        punch_on = 1'b0;
        held_data = 8'h00;
        held_status = 8'h00;
        tape_out = 1'b0;
        reader_media = 1'b0;
        punch_media = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = 1'b0;
        request_taken = 1'b0;
        requests_queued = 0;
        requests_accepted = 0;
        results_checked = 0;
        console_chars = 0;
        punch_chars = 0;
        tape_advances = 0;
        failures = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, both media fitted: console traffic, the printable limits, the
        // punch gate, a tape read to end of tape, a status reset and stray requests.
        write_cfg(CFG_READER_ATTACHED, 1'b1);
        write_cfg(CFG_PUNCH_ATTACHED, 1'b1);
        put(CMD_READ, PORT_STATUS_LO, 8'h00, 8'h00, 1'b0);
        put(CMD_KEY, PORT_DATA_HI, 8'hFF, 8'hFF, 1'b1);
        put(CMD_READ, PORT_STATUS_LO, 8'hFF, 8'h00, 1'b0);
        put(CMD_READ, PORT_DATA_LO, 8'h00, 8'hFF, 1'b1);
        put(CMD_READ, PORT_STATUS_HI, 8'h00, 8'h00, 1'b0);
        put(CMD_READ, PORT_DATA_HI, 8'h00, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, PRINT_FIRST, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, 8'h1F, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, 8'h7F, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, CHAR_DC2, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, PRINT_LAST, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, CHAR_CR, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, CHAR_LF, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, CHAR_DC4, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, 8'hFF, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, CHAR_DC1, 8'h00, 1'b0);
        put(CMD_READ, PORT_DATA_LO, 8'h00, 8'hA5, 1'b0);
        put(CMD_READ, PORT_DATA_LO, 8'h00, 8'h5A, 1'b0);
        put(CMD_READ, PORT_STATUS_LO, 8'h00, 8'h00, 1'b0);
        put(CMD_READ, PORT_DATA_LO, 8'h00, 8'h00, 1'b1);
        put(CMD_READ, PORT_STATUS_LO, 8'h00, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_STATUS_LO, STATUS_RESET_CMD, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_HI, CHAR_DC3, 8'h00, 1'b0);
        put(CMD_UNDEFINED, PORT_DATA_LO, 8'hFF, 8'hFF, 1'b1);
        wait_drained();

        // Reader switched on with no media fitted.
        write_cfg(CFG_READER_ATTACHED, 1'b0);
        put(CMD_READ, PORT_STATUS_LO, 8'h00, 8'h00, 1'b0);
        put(CMD_READ, PORT_DATA_LO, 8'h00, 8'h3C, 1'b0);
        put(CMD_WRITE, PORT_STATUS_LO, 8'h00, 8'h00, 1'b0);
        put(CMD_WRITE, PORT_DATA_LO, CHAR_DC3, 8'h00, 1'b0);
        wait_drained();

        // Random phases: the sender idles rarely and the receiver often, then
        // the reverse, then neither. The media registers are rewritten every phase.
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = (p < 4) ? 14 : (p < 8) ? 76 : 0;
            recv_idle_pct = (p < 4) ? 76 : (p < 8) ? 14 : 0;
            write_cfg(CFG_READER_ATTACHED, (p % 3) != 2);
            write_cfg(CFG_PUNCH_ATTACHED, (p % 4) < 2);
            begin
                int first;
                first = requests_queued;
                while (requests_queued - first < PHASE_REQS)
                    queue_scenario();
            end
            if (p == 6)
            begin
                // Half way through, the sender holds off until the card has
                // answered every request already taken.
                while (pending_requests.size() > PHASE_REQS / 2)
                    @(negedge clk);
                hold_requests = 1'b1;
                while (s_tvalid || expected_results.size() != 0)
                    @(negedge clk);
                hold_requests = 1'b0;
            end
            wait_drained();
        end

        repeat (8) @(negedge clk);
        $display("Checked %0d results for %0d requests over %0d random phases.",
                 results_checked, requests_accepted, PHASES);
        $display("Seen %0d console characters, %0d punch characters, %0d tape advances.",
                 console_chars, punch_chars, tape_advances);
        if (failures == 0 && expected_results.size() == 0)
        begin
            $display("serial_card_with_tape_gating_tb: clean");
        end
        else
        begin
            $display("serial_card_with_tape_gating_tb: errors");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("serial_card_with_tape_gating_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sctg_pkg.sv
rtl/core/sctg_step.sv
rtl/core/serial_card_with_tape_gating.sv
sim/serial_card_with_tape_gating_tb.sv
